// ===== hw/rtl/msce_pkg.sv =====
// Shared types and constants for the multi-stack command engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package msce_pkg;

    localparam int DATA_W     = 32;
    localparam int IN_IDX_W   = 5;
    localparam int CFG_W      = 6;
    localparam int FILL_OUT_W = 7;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(32);

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // One classified command as it travels from the front end to the back end.
    typedef struct packed {
        req_t                req_type;
        logic [IN_IDX_W-1:0] stack_index;
        logic [DATA_W-1:0]   push_value;
        logic                bad_index;
    } cmd_t;

endpackage

// ===== hw/rtl/msce_front.sv =====
// Front end: holds the active stack count and classifies incoming commands.
// Depends on msce_pkg.
`timescale 1ns / 1ps

module msce_front
    import msce_pkg::*;
#(
    parameter int NUM_STACKS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                start,
    input  logic                req_type,
    input  logic [IN_IDX_W-1:0] stack_index,
    input  logic [DATA_W-1:0]   push_value,
    input  logic                queue_full,
    output logic                busy,
    output logic                enq,
    output cmd_t                enq_cmd
);

    localparam logic [8:0] NUM_ST9 = 9'(NUM_STACKS);

    logic [CFG_W-1:0] active_reg;
    logic [CFG_W-1:0] active_next;

    assign active_next = cfg_we ? cfg_wdata : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // An index is bad when it reaches the programmed count or the built count.
    always_comb
    begin
        enq_cmd.req_type    = req_t'(req_type);
        enq_cmd.stack_index = stack_index;
        enq_cmd.push_value  = push_value;
        enq_cmd.bad_index   = (CFG_W'(stack_index) >= active_reg) ||
                              (9'(stack_index) >= NUM_ST9);
    end

    assign busy = queue_full;
    assign enq  = start && !queue_full;

endmodule

// ===== hw/rtl/msce_queue.sv =====
// In-order command queue between the front end and the back end.
// Depends on msce_pkg for the command type.
`timescale 1ns / 1ps

module msce_queue
    import msce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not grow on a lone write");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count did not shrink on a lone read");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with mismatched pointers");
`endif

endmodule

// ===== hw/rtl/msce_back.sv =====
// Back end: fill counters, shared stack memory and the result register.
// Depends on msce_pkg.
`timescale 1ns / 1ps

module msce_back
    import msce_pkg::*;
#(
    parameter int NUM_STACKS  = 32,
    parameter int STACK_DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] popped_value,
    output logic [FILL_OUT_W-1:0]    fill_after
);

    localparam int IDX_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int FILL_W    = $clog2(STACK_DEPTH + 1);
    localparam int MEM_WORDS = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(STACK_DEPTH);

    logic [FILL_W-1:0] fill_reg [NUM_STACKS];
    logic [DATA_W-1:0] mem [MEM_WORDS];

    logic [IDX_W-1:0]  sidx;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_res;
    logic [FILL_W-1:0] offset;
    logic [ADDR_W-1:0] addr;
    logic              upd_en;
    logic              mem_wr;
    logic              mem_rd;
    status_t           status_c;

    logic              done_reg;
    status_t           status_reg;
    logic [FILL_W-1:0] fill_out_reg;
    logic              pop_ok_reg;
    logic [DATA_W-1:0] rdata_reg;

    assign sidx     = IDX_W'(cmd.stack_index);
    assign fill_cur = fill_reg[sidx];

    always_comb
    begin
        status_c  = ST_DONE;
        fill_next = fill_cur;
        fill_res  = fill_cur;
        upd_en    = 1'b0;
        mem_wr    = 1'b0;
        mem_rd    = 1'b0;
        if (cmd.bad_index)
        begin
            status_c = ST_BADIDX;
            fill_res = '0;
        end
        else if (cmd.req_type == REQ_PUSH)
        begin
            if (fill_cur == DEPTH_F)
            begin
                status_c = ST_FULL;
            end
            else
            begin
                fill_next = fill_cur + FILL_W'(1);
                fill_res  = fill_next;
                upd_en    = cmd_valid;
                mem_wr    = cmd_valid;
            end
        end
        else
        begin
            if (fill_cur == '0)
            begin
                status_c = ST_EMPTY;
            end
            else
            begin
                fill_next = fill_cur - FILL_W'(1);
                fill_res  = fill_next;
                upd_en    = cmd_valid;
                mem_rd    = cmd_valid;
            end
        end
    end

    // A push writes at the current fill, a pop reads just below it.
    assign offset = (cmd.req_type == REQ_PUSH) ? fill_cur : fill_next;
    assign addr   = ADDR_W'(sidx) * ADDR_W'(STACK_DEPTH) + ADDR_W'(offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            if (upd_en)
            begin
                fill_reg[sidx] <= fill_next;
            end
            done_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[addr] <= cmd.push_value;
        end
        if (mem_rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_c;
        fill_out_reg <= fill_res;
        pop_ok_reg   <= mem_rd;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = pop_ok_reg ? $signed(rdata_reg) : '0;
    assign fill_after   = FILL_OUT_W'(fill_out_reg);

`ifndef NO_ASSERTIONS
    a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FULL) |-> (fill_out_reg == DEPTH_F))
        else $error("full status without a full stack level");
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_EMPTY || status_reg == ST_BADIDX))
        |-> (fill_out_reg == '0 && !pop_ok_reg))
        else $error("rejected command reports a level or a value");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && mem_wr) |=> (fill_reg[$past(sidx)] == $past(fill_cur) + FILL_W'(1)))
        else $error("push did not raise the fill counter");
    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr && mem_rd))
        else $error("memory written and read by one command");
`endif

endmodule

// ===== hw/rtl/multi_stack_command_engine.sv =====
// Top level of the multi-stack command engine: front end, command queue and back end.
// Depends on msce_pkg, msce_front, msce_queue and msce_back.
`timescale 1ns / 1ps

// A command beat is taken at a rising edge where start is high and busy is low.
// Each command names a stack (stack_index) and either pushes push_value
// (req_type push) or pops the top entry (req_type pop). All stacks share one
// memory; stack s owns STACK_DEPTH consecutive words starting at s*STACK_DEPTH.
// The front end checks the index against active_stacks (written through
// cfg_we/cfg_wdata while the engine is idle, a rule for the user that the block
// does not enforce) and places the command in an in-order queue. The back end
// takes one command per cycle from the queue, updates that stack's fill counter
// and does at most one memory access. A command is held in a queue entry, then in
// the back end's result registers, which drive the result beat (done high for one
// cycle with status, popped_value and fill_after).
// Throughput is one command per cycle, set by the single fill counter update and
// single memory port of the back end. The back end drains the queue every cycle,
// so it never holds more than one entry and busy stays low.
// Reset clears the queue, all fill counters and sets active_stacks to 32;
// stack memory contents are not cleared and are read only where pushed.
// The receiver cannot stall: every result beat is taken in its one cycle.
module multi_stack_command_engine
    import msce_pkg::*;
#(
    parameter int NUM_STACKS  = 32,
    parameter int STACK_DEPTH = 64,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [IN_IDX_W-1:0]      stack_index,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] popped_value,
    output logic [FILL_OUT_W-1:0]    fill_after
);

    // Front end to queue.
    logic enq;
    cmd_t enq_cmd;
    logic queue_full;

    // Queue to back end. The back end never stalls, so it drains the head
    // whenever one is present.
    logic head_valid;
    cmd_t head_cmd;

    msce_front #(
        .NUM_STACKS (NUM_STACKS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .req_type    (req_type),
        .stack_index (stack_index),
        .push_value  (push_value),
        .queue_full  (queue_full),
        .busy        (busy),
        .enq         (enq),
        .enq_cmd     (enq_cmd)
    );

    msce_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (enq),
        .push_cmd  (enq_cmd),
        .pop       (head_valid),
        .full      (queue_full),
        .not_empty (head_valid),
        .head_cmd  (head_cmd)
    );

    msce_back #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .done         (done),
        .status       (status),
        .popped_value (popped_value),
        .fill_after   (fill_after)
    );

endmodule

// ===== bench/multi_stack_command_engine_test.sv =====
// Self-checking testbench for the multi-stack command engine.
// Depends on msce_pkg and multi_stack_command_engine; predicts all but typed results.
`timescale 1ns / 1ps

module multi_stack_command_engine_test;
    import msce_pkg::*;

    localparam int NUM_STACKS  = 32;
    localparam int STACK_DEPTH = 64;
    localparam int QUEUE_DEPTH = 8;

    // Cycles in which no command beat and no result beat is taken before the run
    // is declared hung.  The slowest legal stretch is a drain plus a config write
    // plus a sender gap.
    localparam int QUIET_LIMIT = 2000;

    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DIRECTED_ROWS  = 22;

    // One result beat as the engine reports it.
    typedef struct {
        status_t     st;
        logic [31:0] pop;
        logic [6:0]  fill;
    } stack_result_t;

    // One row of the directed plan.  A row can first change the number of active
    // stacks, and it can carry an expected result typed in by hand.
    typedef struct {
        bit          set_cfg;
        logic [5:0]  cfg_val;
        req_t        req;
        logic [4:0]  idx;
        logic [31:0] val;
        bit          typed;
        status_t     st;
        logic [31:0] pop;
        logic [6:0]  fill;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              start;
    logic              busy;
    logic              req_type;
    logic [4:0]        stack_index;
    logic signed [31:0] push_value;
    logic              done;
    logic [1:0]        status;
    logic signed [31:0] popped_value;
    logic [6:0]        fill_after;

    // Shadow of the engine: the stack words, the fill level of every stack and
    // the active stack count.
    logic [31:0]   stack_words [NUM_STACKS][STACK_DEPTH];
    int            stack_level [NUM_STACKS];
    logic [5:0]    active_cfg;

    // Expected result beats, oldest first.
    stack_result_t pending_results [$];

    // The driver marks a command whose result was typed in by hand.
    bit            typed_now;
    stack_result_t typed_result;

    plan_row_t     directed_rows [DIRECTED_ROWS];

    int mismatch_count;
    int commands_taken;
    int results_seen;
    int config_writes;
    int quiet_cycles;
    int status_seen [4];

    multi_stack_command_engine #(
        .NUM_STACKS (NUM_STACKS),
        .STACK_DEPTH(STACK_DEPTH),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .stack_index (stack_index),
        .push_value  (push_value),
        .done        (done),
        .status      (status),
        .popped_value(popped_value),
        .fill_after  (fill_after)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one command and updates the shadow stacks.
    // Counts above the number of stacks behave as the full set, and a count of
    // zero turns every index away.
    function automatic stack_result_t apply_stack_command(req_t kind, logic [4:0] idx,
                                                          logic [31:0] value);
        stack_result_t r;
        int lim;
        int lvl;
        r.st   = ST_DONE;
        r.pop  = '0;
        r.fill = '0;
        lim = (int'(active_cfg) > NUM_STACKS) ? NUM_STACKS : int'(active_cfg);
        if (int'(idx) >= lim)
        begin
            r.st = ST_BADIDX;
        end
        else
        begin
            lvl = stack_level[idx];
            if (kind == REQ_PUSH)
            begin
                if (lvl >= STACK_DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    stack_words[idx][lvl] = value;
                    lvl++;
                    stack_level[idx] = lvl;
                end
            end
            else
            begin
                if (lvl == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    lvl--;
                    r.pop = stack_words[idx][lvl];
                    stack_level[idx] = lvl;
                end
            end
            r.fill = 7'(lvl);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t, result beat %0d, %s: got %0h, expected %0h",
                 $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Everything on the engine's outputs is sampled here, at the rising edge.
    // Result beats are checked before the command beat of the same edge is
    // predicted, so the queue order always matches the engine's order.
    always @(posedge clk)
    begin : monitor
        stack_result_t want;
        stack_result_t pred;
        bit            active;
        active = 1'b0;
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
            begin
                active = 1'b1;
                results_seen++;
                status_seen[status]++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending", 32'(status), '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (popped_value !== want.pop)
                        report_mismatch("popped_value", popped_value, want.pop);
                    if (fill_after !== want.fill)
                        report_mismatch("fill_after", 32'(fill_after), 32'(want.fill));
                end
            end

            if (cfg_we === 1'b1)
                active_cfg = cfg_wdata;

            // A command beat is taken when start is high and busy is low.
            if (start === 1'b1 && busy === 1'b0)
            begin
                active = 1'b1;
                commands_taken++;
                pred = apply_stack_command(req_t'(req_type), stack_index, push_value);
                pending_results.push_back(typed_now ? typed_result : pred);
            end

            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no beat taken for %0d cycles", QUIET_LIMIT);
                $display("multi_stack_command_engine_test NOT OK");
                $finish;
            end
        end
    end

    // Presents one command beat from the falling edge on and holds it until the
    // engine takes it.  The next beat, or a lowered start, follows at the next
    // falling edge, so start is never dropped and raised within one time step.
    task automatic send_command(req_t kind, logic [4:0] idx, logic [31:0] value,
                                bit typed, stack_result_t typed_res);
        @(negedge clk);
        start        = 1'b1;
        req_type     = kind;
        stack_index  = idx;
        push_value   = value;
        typed_now    = typed;
        typed_result = typed_res;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic idle_cycles(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Holds the sender off until every expected beat has come back.  Every
    // command yields a result, so the wait always ends.
    task automatic drain_engine();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Writes the active stack count.  Only called right after a drain, so the
    // engine is idle and the write lands on the next rising edge.
    task automatic write_active_stacks(logic [5:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        config_writes++;
    endtask

    initial
    begin
        logic [5:0]    phase_cfg [PHASES];
        int            push_pct [PHASES];
        logic [5:0]    cfg;
        int            lim;
        req_t          kind;
        logic [4:0]    idx;
        logic [31:0]   value;
        stack_result_t no_result;

        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        start        = 1'b0;
        req_type     = 1'b0;
        stack_index  = '0;
        push_value   = '0;
        typed_now    = 1'b0;
        typed_result = '{ST_DONE, '0, '0};
        no_result    = '{ST_DONE, '0, '0};
        active_cfg   = ACTIVE_RESET;
        for (int s = 0; s < NUM_STACKS; s++)
            stack_level[s] = 0;
        for (int k = 0; k < 4; k++)
            status_seen[k] = 0;
        mismatch_count = 0;
        commands_taken = 0;
        results_seen   = 0;
        config_writes  = 0;
        quiet_cycles   = 0;

        // Directed plan.  Rows marked typed carry a result that is plain from the
        // row itself; all others are left to the predictor.
        directed_rows = '{
            // Pops on empty stacks at both ends of the index range.
            '{1'b0, 6'd0,  REQ_POP,  5'd0,  32'h0000_0000, 1'b1, ST_EMPTY,  32'h0, 7'd0},
            '{1'b0, 6'd0,  REQ_POP,  5'd31, 32'h0000_0000, 1'b1, ST_EMPTY,  32'h0, 7'd0},
            // Extreme values pushed and popped back in LIFO order.
            '{1'b0, 6'd0,  REQ_PUSH, 5'd0,  32'h7FFF_FFFF, 1'b1, ST_DONE,   32'h0, 7'd1},
            '{1'b0, 6'd0,  REQ_PUSH, 5'd0,  32'h8000_0000, 1'b1, ST_DONE,   32'h0, 7'd2},
            '{1'b0, 6'd0,  REQ_POP,  5'd0,  32'hDEAD_BEEF, 1'b1, ST_DONE,
              32'h8000_0000, 7'd1},
            '{1'b0, 6'd0,  REQ_POP,  5'd0,  32'h0000_0000, 1'b1, ST_DONE,
              32'h7FFF_FFFF, 7'd0},
            '{1'b0, 6'd0,  REQ_PUSH, 5'd31, 32'hFFFF_FFFF, 1'b1, ST_DONE,   32'h0, 7'd1},
            '{1'b0, 6'd0,  REQ_PUSH, 5'd31, 32'h0000_0000, 1'b1, ST_DONE,   32'h0, 7'd2},
            '{1'b0, 6'd0,  REQ_POP,  5'd31, 32'hFFFF_FFFF, 1'b1, ST_DONE,   32'h0, 7'd1},
            '{1'b0, 6'd0,  REQ_POP,  5'd31, 32'h0000_0000, 1'b1, ST_DONE,
              32'hFFFF_FFFF, 7'd0},
            '{1'b0, 6'd0,  REQ_PUSH, 5'd17, 32'h5555_AAAA, 1'b0, ST_DONE,   32'h0, 7'd0},
            '{1'b0, 6'd0,  REQ_PUSH, 5'd17, 32'hAAAA_5555, 1'b0, ST_DONE,   32'h0, 7'd0},
            // A single active stack: every other index is turned away.
            '{1'b1, 6'd1,  REQ_PUSH, 5'd1,  32'hC0FF_EE00, 1'b1, ST_BADIDX, 32'h0, 7'd0},
            '{1'b0, 6'd0,  REQ_POP,  5'd31, 32'h0000_0000, 1'b1, ST_BADIDX, 32'h0, 7'd0},
            '{1'b0, 6'd0,  REQ_PUSH, 5'd0,  32'h1234_5678, 1'b1, ST_DONE,   32'h0, 7'd1},
            // No active stacks at all.
            '{1'b1, 6'd0,  REQ_PUSH, 5'd0,  32'h0000_0001, 1'b1, ST_BADIDX, 32'h0, 7'd0},
            '{1'b0, 6'd0,  REQ_POP,  5'd0,  32'h0000_0000, 1'b1, ST_BADIDX, 32'h0, 7'd0},
            // Counts above the number of stacks act as the full set.
            '{1'b1, 6'd63, REQ_POP,  5'd17, 32'h0000_0000, 1'b0, ST_DONE,   32'h0, 7'd0},
            '{1'b0, 6'd0,  REQ_PUSH, 5'd31, 32'h0000_0001, 1'b0, ST_DONE,   32'h0, 7'd0},
            '{1'b1, 6'd33, REQ_POP,  5'd31, 32'h0000_0000, 1'b0, ST_DONE,   32'h0, 7'd0},
            '{1'b0, 6'd0,  REQ_POP,  5'd0,  32'h0000_0000, 1'b0, ST_DONE,   32'h0, 7'd0},
            '{1'b1, 6'd32, REQ_POP,  5'd17, 32'h0000_0000, 1'b0, ST_DONE,   32'h0, 7'd0}
        };

        // Random phases.  A single stack with heavy pushes runs it full, and the
        // next phase drains it past empty.  Phase 0 is the stretch without gaps.
        phase_cfg = '{6'd32, 6'd1, 6'd1, 6'd2, 6'd63, 6'd0, 6'd17, 6'd33};
        push_pct  = '{50, 85, 20, 70, 55, 50, 60, 40};

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].set_cfg)
            begin
                drain_engine();
                write_active_stacks(directed_rows[i].cfg_val);
            end
            send_command(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].val,
                         directed_rows[i].typed,
                         '{directed_rows[i].st, directed_rows[i].pop, directed_rows[i].fill});
        end

        for (int p = 0; p < PHASES; p++)
        begin
            cfg = (p == 6) ? 6'($urandom_range(31, 2)) : phase_cfg[p];
            drain_engine();
            write_active_stacks(cfg);
            lim = (int'(cfg) > NUM_STACKS) ? NUM_STACKS : int'(cfg);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Once, in the middle of phase 3, the sender waits for every result.
                if (p == 3 && k == ITEMS_PER_PHASE / 2)
                    drain_engine();
                if (p != 0 && $urandom_range(99) < 18)
                    idle_cycles($urandom_range(4, 1));

                kind = ($urandom_range(99) < push_pct[p]) ? REQ_PUSH : REQ_POP;
                // Most beats address a stack in use; the rest roam the full index
                // range so that bad indices and every index bit are exercised.
                if (lim != 0 && $urandom_range(99) < 85)
                    idx = 5'($urandom_range(lim - 1, 0));
                else
                    idx = 5'($urandom_range(31, 0));
                case ($urandom_range(19))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'hFFFF_FFFF;
                    3:       value = 32'h0000_0000;
                    default: value = $urandom;
                endcase
                send_command(kind, idx, value, 1'b0, no_result);
            end
        end

        drain_engine();
        repeat (8) @(negedge clk);

        $display("Ran %0d commands through %0d active-stack settings, extremes included.",
                 commands_taken, config_writes + 1);
        $display("Result beats: %0d done, %0d empty pops, %0d full pushes, %0d bad indices.",
                 status_seen[ST_DONE], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_BADIDX]);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("multi_stack_command_engine_test OK");
        else
            $display("multi_stack_command_engine_test NOT OK");
        $finish;
    end

endmodule
